>>> hdl/ppls_pkg.sv
// Shared types, constants and helpers for the Phong point-light shader.
// Used by the front, back and top modules; depends on nothing else.

package ppls_pkg;

  // Defaults of the top-level parameters
  localparam int COLOR_FRAC_BITS_DEF = 12;
  localparam int COORD_WIDTH_DEF     = 32;
  localparam int SHINE_BITS_DEF      = 16;

  // Fixed field widths and fixed-point constants
  localparam int VEC_W      = 16;
  localparam int CHAN_W     = 16;
  localparam int UNIT_Q14   = 16384;
  localparam int NORM_BITS  = 30;
  localparam int QUO_BITS   = 15;
  localparam int SQRT_STEPS = 32;
  localparam int FIFO_DEPTH = 4;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CHAN_W-1:0] LIGHT_COLOR_RESET = 16'h1000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_RED   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_GREEN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_BLUE  = 3'd5;

  typedef logic [VEC_W-1:0] vec_t;

  // Per-item attributes that ride along with the geometry
  typedef struct packed {
    vec_t [2:0]  eye;
    vec_t [2:0]  nrm;
    logic [47:0] color;
    logic [63:0] coeffs;
  } attr_t;

  // Front-to-back beat: unit light vector plus attributes
  typedef struct packed {
    vec_t [2:0] lv;
    attr_t      attr;
  } lvec_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  // Q1.14 multiply with round half up; operands are at most 1.0
  function automatic logic [14:0] qmul14(input logic [14:0] a, input logic [14:0] b);
    logic [29:0] p;
    p = 30'(a) * 30'(b) + 30'(UNIT_Q14 / 2);
    return p[28:14];
  endfunction

endpackage

>>> hdl/ppls_fifo.sv
// Small register queue with full and empty flags.
// Decouples the shader stages; no package dependencies.

module ppls_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> hdl/ppls_front.sv
// Front half: light vector, normalization, square root and division.
// Produces a unit light vector per item; depends on ppls_pkg.

module ppls_front import ppls_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [COORD_WIDTH-1:0] point_x,
  input  logic [COORD_WIDTH-1:0] point_y,
  input  logic [COORD_WIDTH-1:0] point_z,
  input  attr_t                  in_attr,
  input  logic [COORD_WIDTH-1:0] light_x,
  input  logic [COORD_WIDTH-1:0] light_y,
  input  logic [COORD_WIDTH-1:0] light_z,
  input  logic                   mid_full,
  output logic                   mid_push,
  output lvec_t                  mid_data
);

  localparam int DW    = COORD_WIDTH + 1;
  localparam int NW    = (DW > NORM_BITS) ? DW : NORM_BITS;
  localparam int BW    = $clog2(DW + 1);
  localparam int REM_W = NORM_BITS + QUO_BITS + 2;

  typedef struct packed {
    logic [2:0][NORM_BITS-1:0] nm;
    logic [2:0]                neg;
    logic                      zero;
    attr_t                     attr;
  } nrm_t;

  logic adv;

  // Stage 1: difference and magnitude
  logic [2:0][DW-1:0] mag1_r;
  logic [2:0]         neg1_r;
  attr_t              attr1_r;
  logic               v1_r;
  // Stage 2: largest magnitude
  logic [2:0][DW-1:0] mag2_r;
  logic [DW-1:0]      maxm2_r;
  logic [2:0]         neg2_r;
  attr_t              attr2_r;
  logic               v2_r;
  // Stage 3: normalized magnitudes
  nrm_t               c3_r;
  logic               v3_r;
  // Stage 4: squares
  logic [2:0][2*NORM_BITS-1:0] sq4_r;
  nrm_t                        c4_r;
  logic                        v4_r;
  // Square-root steps
  logic [63:0] sq_s_r   [SQRT_STEPS+1];
  logic [63:0] sq_res_r [SQRT_STEPS+1];
  nrm_t        sq_c_r   [SQRT_STEPS+1];
  logic        sq_v_r   [SQRT_STEPS+1];
  // Division steps
  logic [2:0][REM_W-1:0]    dv_rem_r [QUO_BITS+1];
  logic [2:0][QUO_BITS-1:0] dv_q_r   [QUO_BITS+1];
  logic [31:0]              dv_rt_r  [QUO_BITS+1];
  nrm_t                     dv_c_r   [QUO_BITS+1];
  logic                     dv_v_r   [QUO_BITS+1];
  // Final: signed unit vector
  lvec_t fin_r;
  logic  fin_v_r;

  // Hold everything while the last beat cannot leave
  assign adv      = !(fin_v_r && mid_full);
  assign in_stall = !adv;
  assign mid_push = fin_v_r && !mid_full;
  assign mid_data = fin_r;

  // Stage 1 datapath
  logic [2:0][COORD_WIDTH-1:0] lpos, ppos;
  logic [2:0][DW-1:0]          d1;
  assign lpos = {light_z, light_y, light_x};
  assign ppos = {point_z, point_y, point_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d1[i] = {lpos[i][COORD_WIDTH-1], lpos[i]} - {ppos[i][COORD_WIDTH-1], ppos[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        neg1_r[i] <= d1[i][DW-1];
        mag1_r[i] <= d1[i][DW-1] ? (~d1[i] + 1'b1) : d1[i];
      end
      attr1_r <= in_attr;
    end
  end

  // Stage 2 datapath
  logic [DW-1:0] max01;
  assign max01 = (mag1_r[0] > mag1_r[1]) ? mag1_r[0] : mag1_r[1];

  always_ff @(posedge clk) begin
    if (adv) begin
      mag2_r  <= mag1_r;
      maxm2_r <= (max01 > mag1_r[2]) ? max01 : mag1_r[2];
      neg2_r  <= neg1_r;
      attr2_r <= attr1_r;
    end
  end

  // Stage 3: place the largest magnitude in [2^29, 2^30)
  logic [BW-1:0] lead;
  nrm_t          c3_nxt;

  always_comb begin
    logic [NW-1:0] ext;
    lead = '0;
    for (int i = 0; i < DW; i++) begin
      if (maxm2_r[i]) begin
        lead = BW'(i + 1);
      end
    end
    c3_nxt.neg  = neg2_r;
    c3_nxt.zero = (maxm2_r == '0);
    c3_nxt.attr = attr2_r;
    for (int i = 0; i < 3; i++) begin
      ext = NW'(mag2_r[i]);
      if (lead > BW'(NORM_BITS)) begin
        ext = ext >> (lead - BW'(NORM_BITS));
      end else begin
        ext = ext << (BW'(NORM_BITS) - lead);
      end
      c3_nxt.nm[i] = ext[NORM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c3_r <= c3_nxt;
    end
  end

  // Stage 4: squares
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq4_r[i] <= c3_r.nm[i] * c3_r.nm[i];
      end
      c4_r <= c3_r;
    end
  end

  // Stage 5: sum of squares, seeds the root
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_s_r[0]   <= 64'(sq4_r[0]) + 64'(sq4_r[1]) + 64'(sq4_r[2]);
      sq_res_r[0] <= '0;
      sq_c_r[0]   <= c4_r;
    end
  end

  // Integer square root, one result bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = sq_res_r[k] + BIT;

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_c_r[k+1] <= sq_c_r[k];
        if (sq_s_r[k] >= trial) begin
          sq_s_r[k+1]   <= sq_s_r[k] - trial;
          sq_res_r[k+1] <= (sq_res_r[k] >> 1) + BIT;
        end else begin
          sq_s_r[k+1]   <= sq_s_r[k];
          sq_res_r[k+1] <= sq_res_r[k] >> 1;
        end
      end
    end
  end

  // Seed the dividers with magnitude * 2^14
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= REM_W'(sq_c_r[SQRT_STEPS].nm[i]) << 14;
      end
      dv_q_r[0]  <= '0;
      dv_rt_r[0] <= sq_res_r[SQRT_STEPS][31:0];
      dv_c_r[0]  <= sq_c_r[SQRT_STEPS];
    end
  end

  // Restoring division, one quotient bit per stage, three lanes
  for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
    localparam int J = QUO_BITS - 1 - k;
    logic [REM_W-1:0] dvs;
    assign dvs = REM_W'(dv_rt_r[k]) << J;

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rt_r[k+1] <= dv_rt_r[k];
        dv_c_r[k+1]  <= dv_c_r[k];
        for (int i = 0; i < 3; i++) begin
          if (dv_rem_r[k][i] >= dvs) begin
            dv_rem_r[k+1][i]  <= dv_rem_r[k][i] - dvs;
            dv_q_r[k+1][i]    <= dv_q_r[k][i] | (QUO_BITS'(1) << J);
          end else begin
            dv_rem_r[k+1][i]  <= dv_rem_r[k][i];
            dv_q_r[k+1][i]    <= dv_q_r[k][i];
          end
        end
      end
    end
  end

  // Apply sign; a light at the point gives the zero vector
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_c_r[QUO_BITS].zero) begin
          fin_r.lv[i] <= '0;
        end else if (dv_c_r[QUO_BITS].neg[i]) begin
          fin_r.lv[i] <= VEC_W'(-VEC_W'(dv_q_r[QUO_BITS][i]));
        end else begin
          fin_r.lv[i] <= VEC_W'(dv_q_r[QUO_BITS][i]);
        end
      end
      fin_r.attr <= dv_c_r[QUO_BITS].attr;
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      fin_v_r <= 1'b0;
      for (int k = 0; k <= SQRT_STEPS; k++) begin
        sq_v_r[k] <= 1'b0;
      end
      for (int k = 0; k <= QUO_BITS; k++) begin
        dv_v_r[k] <= 1'b0;
      end
    end else if (adv) begin
      v1_r      <= in_valid;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      sq_v_r[0] <= v4_r;
      for (int k = 0; k < SQRT_STEPS; k++) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
      dv_v_r[0] <= sq_v_r[SQRT_STEPS];
      for (int k = 0; k < QUO_BITS; k++) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
      fin_v_r <= dv_v_r[QUO_BITS];
    end
  end

endmodule

>>> hdl/ppls_back.sv
// Back half: dot products, reflection, specular power and colour mix.
// Consumes unit light vectors from the middle queue; depends on ppls_pkg.

module ppls_back import ppls_pkg::*; #(
  parameter int COLOR_FRAC_BITS = COLOR_FRAC_BITS_DEF,
  parameter int SHINE_BITS      = SHINE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              mid_empty,
  output logic              mid_pop,
  input  lvec_t             mid_data,
  input  logic [CHAN_W-1:0] light_red,
  input  logic [CHAN_W-1:0] light_green,
  input  logic [CHAN_W-1:0] light_blue,
  input  logic              out_full,
  output logic              out_push,
  output rgb_t              out_data
);

  localparam int OUT_SHIFT = 2 * COLOR_FRAC_BITS + 14;

  typedef struct packed {
    logic [14:0]           lq;
    logic [47:0]           color;
    logic [63:0]           coeffs;
    logic [SHINE_BITS-1:0] sh;
  } mix_t;

  logic adv;

  logic signed [31:0] ln1_r [3];
  lvec_t              b1_r;
  logic               v1_r;

  logic [14:0] lq2_r;
  logic        lneg2_r;
  lvec_t       b2_r;
  logic        v2_r;

  logic signed [32:0] p3_r [3];
  logic [14:0]        lq3_r;
  logic               lneg3_r;
  lvec_t              b3_r;
  logic               v3_r;

  logic signed [19:0] r4_r [3];
  logic [14:0]        lq4_r;
  logic               lneg4_r;
  lvec_t              b4_r;
  logic               v4_r;

  logic signed [35:0] re5_r [3];
  logic [14:0]        lq5_r;
  logic               lneg5_r;
  lvec_t              b5_r;
  logic               v5_r;

  logic [14:0] pw_r   [SHINE_BITS+1];
  logic [14:0] base_r [SHINE_BITS+1];
  mix_t        pm_r   [SHINE_BITS+1];
  logic        pv_r   [SHINE_BITS+1];

  logic [31:0] mc_c1_r [3];
  logic [31:0] cks_c1_r [3];
  logic [14:0] pw_c1_r;
  mix_t        m_c1_r;
  logic        v_c1_r;

  logic [47:0] a_c2_r [3];
  logic [47:0] t_c2_r [3];
  logic [46:0] u_c2_r [3];
  logic [14:0] lq_c2_r;
  logic        v_c2_r;

  logic [47:0] a_c3_r [3];
  logic [62:0] tl_c3_r [3];
  logic [46:0] u_c3_r [3];
  logic        v_c3_r;

  rgb_t        res_c4_r;
  logic        v_c4_r;

  // Hold the pipe while the finished beat cannot leave
  assign adv      = !(v_c4_r && out_full);
  assign mid_pop  = adv && !mid_empty;
  assign out_push = v_c4_r && !out_full;
  assign out_data = res_c4_r;

  // B1: light dot normal products
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ln1_r[i] <= $signed(mid_data.lv[i]) * $signed(mid_data.attr.nrm[i]);
      end
      b1_r <= mid_data;
    end
  end

  // B2: diffuse factor, clamped to zero when negative and capped at 1.0
  logic signed [33:0] ldn;
  logic signed [19:0] lf;
  assign ldn = 34'(ln1_r[0]) + 34'(ln1_r[1]) + 34'(ln1_r[2]);
  assign lf  = 20'(ldn >>> 14);

  always_ff @(posedge clk) begin
    if (adv) begin
      lneg2_r <= ldn[33];
      if (ldn[33]) begin
        lq2_r <= '0;
      end else if (lf > 20'sd16384) begin
        lq2_r <= 15'(UNIT_Q14);
      end else begin
        lq2_r <= lf[14:0];
      end
      b2_r <= b1_r;
    end
  end

  // B3: 2 * L * n
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p3_r[i] <= $signed({1'b0, lq2_r, 1'b0}) * $signed(b2_r.attr.nrm[i]);
      end
      lq3_r   <= lq2_r;
      lneg3_r <= lneg2_r;
      b3_r    <= b2_r;
    end
  end

  // B4: reflection vector, floor shift keeps the sign
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        r4_r[i] <= 20'(p3_r[i] >>> 14) - 20'($signed(b3_r.lv[i]));
      end
      lq4_r   <= lq3_r;
      lneg4_r <= lneg3_r;
      b4_r    <= b3_r;
    end
  end

  // B5: reflection dot eye products
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        re5_r[i] <= r4_r[i] * $signed(b4_r.attr.eye[i]);
      end
      lq5_r   <= lq4_r;
      lneg5_r <= lneg4_r;
      b5_r    <= b4_r;
    end
  end

  // B6: specular base; a dead specular term starts the power at zero
  logic signed [37:0] rde;
  logic signed [23:0] ff;
  logic               spec_on;
  mix_t               pm_nxt;
  assign rde     = 38'(re5_r[0]) + 38'(re5_r[1]) + 38'(re5_r[2]);
  assign ff      = 24'(rde >>> 14);
  assign spec_on = !lneg5_r && !rde[37] && (rde != '0);

  always_comb begin
    pm_nxt.lq     = lq5_r;
    pm_nxt.color  = b5_r.attr.color;
    pm_nxt.coeffs = b5_r.attr.coeffs;
    pm_nxt.sh     = b5_r.attr.coeffs[SHINE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pw_r[0] <= spec_on ? 15'(UNIT_Q14) : '0;
      if (ff > 24'sd16384) begin
        base_r[0] <= 15'(UNIT_Q14);
      end else begin
        base_r[0] <= ff[14:0];
      end
      pm_r[0] <= pm_nxt;
    end
  end

  // Power by repeated squaring, one shininess bit per stage
  for (genvar k = 0; k < SHINE_BITS; k++) begin : g_pow
    always_ff @(posedge clk) begin
      if (adv) begin
        pw_r[k+1]   <= pm_r[k].sh[k] ? qmul14(pw_r[k], base_r[k]) : pw_r[k];
        base_r[k+1] <= qmul14(base_r[k], base_r[k]);
        pm_r[k+1]   <= pm_r[k];
      end
    end
  end

  // C1: material times light colour, light times specular
  logic [2:0][CHAN_W-1:0] lcol;
  logic [2:0][CHAN_W-1:0] mcol;
  assign lcol = {light_blue, light_green, light_red};
  assign mcol = {pm_r[SHINE_BITS].color[15:0], pm_r[SHINE_BITS].color[31:16],
                 pm_r[SHINE_BITS].color[47:32]};

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        mc_c1_r[i]  <= mcol[i] * lcol[i];
        cks_c1_r[i] <= lcol[i] * pm_r[SHINE_BITS].coeffs[31:16];
      end
      pw_c1_r <= pw_r[SHINE_BITS];
      m_c1_r  <= pm_r[SHINE_BITS];
    end
  end

  // C2: scale by the coefficients and the power
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a_c2_r[i] <= 48'(mc_c1_r[i]) * 48'(m_c1_r.coeffs[63:48]);
        t_c2_r[i] <= 48'(mc_c1_r[i]) * 48'(m_c1_r.coeffs[47:32]);
        u_c2_r[i] <= 47'(cks_c1_r[i]) * 47'(pw_c1_r);
      end
      lq_c2_r <= m_c1_r.lq;
    end
  end

  // C3: diffuse times L
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        tl_c3_r[i] <= 63'(t_c2_r[i]) * 63'(lq_c2_r);
      end
      a_c3_r <= a_c2_r;
      u_c3_r <= u_c2_r;
    end
  end

  // C4: add terms, round and saturate
  logic [2:0][CHAN_W-1:0] chan;
  always_comb begin
    logic [63:0] sum;
    logic [63:0] v;
    for (int i = 0; i < 3; i++) begin
      sum = (64'(a_c3_r[i]) << 14) + 64'(tl_c3_r[i])
          + (64'(u_c3_r[i]) << COLOR_FRAC_BITS) + (64'(1) << (OUT_SHIFT - 1));
      v = sum >> OUT_SHIFT;
      chan[i] = (v > 64'(16'hFFFF)) ? 16'hFFFF : v[CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_c4_r.red   <= chan[0];
      res_c4_r.green <= chan[1];
      res_c4_r.blue  <= chan[2];
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      v5_r   <= 1'b0;
      v_c1_r <= 1'b0;
      v_c2_r <= 1'b0;
      v_c3_r <= 1'b0;
      v_c4_r <= 1'b0;
      for (int k = 0; k <= SHINE_BITS; k++) begin
        pv_r[k] <= 1'b0;
      end
    end else if (adv) begin
      v1_r    <= !mid_empty;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      v5_r    <= v4_r;
      pv_r[0] <= v5_r;
      for (int k = 0; k < SHINE_BITS; k++) begin
        pv_r[k+1] <= pv_r[k];
      end
      v_c1_r <= pv_r[SHINE_BITS];
      v_c2_r <= v_c1_r;
      v_c3_r <= v_c2_r;
      v_c4_r <= v_c3_r;
    end
  end

endmodule

>>> hdl/phong_point_light_shader.sv
// Phong point-light shader, top level: light registers, front, back and queues.
// Depends on ppls_pkg, ppls_fifo, ppls_front and ppls_back.
//
// Usage:
//   Input side: drive the in_ fields and raise push; a beat is taken on a
//   clock edge with push high and full low. One shading request per beat.
//   Result queue: while empty is low the oldest colour is on out_red,
//   out_green and out_blue; raise pop to take it.
//   Configuration: cfg_valid with cfg_index and cfg_data writes one light
//   register; cfg_ready is always high. Write only while the block is idle.
// Throughput: one request per cycle, sustained, while results are drained.
// Pipeline: the front has 4 setup stages, 1 sum stage, 32 square-root stages,
//   1 divider seed stage, 15 divider stages and 1 sign stage; results then pass
//   through the middle queue and the back pipeline up to the result queue.
// Reset: queues and pipelines empty, light at the origin with colour 1.0.
// Stall: when pop stays low the result queue fills, the back pipe holds,
//   then the middle queue fills and the front holds; full rises and no
//   request is lost.

module phong_point_light_shader import ppls_pkg::*; #(
  parameter int COLOR_FRAC_BITS = COLOR_FRAC_BITS_DEF,
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int SHINE_BITS      = SHINE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  logic [COORD_WIDTH-1:0] in_point_x,
  input  logic [COORD_WIDTH-1:0] in_point_y,
  input  logic [COORD_WIDTH-1:0] in_point_z,
  input  logic [VEC_W-1:0]       in_eye_x,
  input  logic [VEC_W-1:0]       in_eye_y,
  input  logic [VEC_W-1:0]       in_eye_z,
  input  logic [VEC_W-1:0]       in_normal_x,
  input  logic [VEC_W-1:0]       in_normal_y,
  input  logic [VEC_W-1:0]       in_normal_z,
  input  logic [47:0]            in_surface_color,
  input  logic [63:0]            in_surface_coeffs,
  output logic                   empty,
  input  logic                   pop,
  output logic [CHAN_W-1:0]      out_red,
  output logic [CHAN_W-1:0]      out_green,
  output logic [CHAN_W-1:0]      out_blue,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COORD_WIDTH-1:0] cfg_data
);

  logic [COORD_WIDTH-1:0] light_x_r, light_y_r, light_z_r;
  logic [CHAN_W-1:0]      light_red_r, light_green_r, light_blue_r;

  assign cfg_ready = 1'b1;

  // Light registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_x_r     <= '0;
      light_y_r     <= '0;
      light_z_r     <= '0;
      light_red_r   <= LIGHT_COLOR_RESET;
      light_green_r <= LIGHT_COLOR_RESET;
      light_blue_r  <= LIGHT_COLOR_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LIGHT_X:     light_x_r     <= cfg_data;
        REG_LIGHT_Y:     light_y_r     <= cfg_data;
        REG_LIGHT_Z:     light_z_r     <= cfg_data;
        REG_LIGHT_RED:   light_red_r   <= cfg_data[CHAN_W-1:0];
        REG_LIGHT_GREEN: light_green_r <= cfg_data[CHAN_W-1:0];
        REG_LIGHT_BLUE:  light_blue_r  <= cfg_data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Gather the attributes of a request
  attr_t in_attr;
  assign in_attr.eye    = {in_eye_z, in_eye_y, in_eye_x};
  assign in_attr.nrm    = {in_normal_z, in_normal_y, in_normal_x};
  assign in_attr.color  = in_surface_color;
  assign in_attr.coeffs = in_surface_coeffs;

  logic  front_stall;
  logic  mid_full, mid_push, mid_empty, mid_pop;
  lvec_t mid_din, mid_dout;
  logic  res_full, res_push;
  rgb_t  res_din, res_dout;

  assign full = front_stall;

  ppls_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (push),
    .in_stall (front_stall),
    .point_x  (in_point_x),
    .point_y  (in_point_y),
    .point_z  (in_point_z),
    .in_attr  (in_attr),
    .light_x  (light_x_r),
    .light_y  (light_y_r),
    .light_z  (light_z_r),
    .mid_full (mid_full),
    .mid_push (mid_push),
    .mid_data (mid_din)
  );

  ppls_fifo #(
    .W    ($bits(lvec_t)),
    .DEPTH(FIFO_DEPTH)
  ) u_mid_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (mid_push),
    .din  (mid_din),
    .full (mid_full),
    .pop  (mid_pop),
    .dout (mid_dout),
    .empty(mid_empty)
  );

  ppls_back #(
    .COLOR_FRAC_BITS(COLOR_FRAC_BITS),
    .SHINE_BITS     (SHINE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .mid_empty  (mid_empty),
    .mid_pop    (mid_pop),
    .mid_data   (mid_dout),
    .light_red  (light_red_r),
    .light_green(light_green_r),
    .light_blue (light_blue_r),
    .out_full   (res_full),
    .out_push   (res_push),
    .out_data   (res_din)
  );

  ppls_fifo #(
    .W    ($bits(rgb_t)),
    .DEPTH(FIFO_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .din  (res_din),
    .full (res_full),
    .pop  (pop),
    .dout (res_dout),
    .empty(empty)
  );

  assign out_red   = res_dout.red;
  assign out_green = res_dout.green;
  assign out_blue  = res_dout.blue;

endmodule
